@@ rtl/awmm_pkg.sv @@
// ----------------------------------------------------------------------------
// awmm_pkg: shared types and constants of the airflow window majority monitor
// Class codes, operation codes, register indexes, widths and the majority rule.
// ----------------------------------------------------------------------------
package awmm_pkg;

  localparam int WINDOW_DEPTH = 128;
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int CNT_W        = LEN_W;
  localparam int CMP_W        = (LEN_W > 8) ? LEN_W : 8;

  localparam int READING_W    = 8;
  localparam int COUNT_W      = 8;
  localparam int LIMIT_W      = 8;
  localparam int IN_TDATA_W   = 24;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_FIELDS_W = 9;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 8;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(WINDOW_DEPTH);
  localparam logic [LEN_W-1:0] RESET_LEN =
    (100 > WINDOW_DEPTH) ? LEN_W'(WINDOW_DEPTH) : LEN_W'(100);
  localparam logic [READING_W-1:0] RESET_READING = 8'd255;

  typedef enum logic [1:0] {
    CLS_OK       = 2'd0,
    CLS_CAUTION  = 2'd1,
    CLS_CRITICAL = 2'd2,
    CLS_EMPTY    = 2'd3
  } cls_t;

  localparam logic [1:0] Q_DISCONNECTED = 2'd3;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CAUTION  = 3'd0,
    CFG_CRITICAL = 3'd1,
    CFG_FAULT    = 3'd2,
    CFG_BYPASS   = 3'd3,
    CFG_WINLEN   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_S_UPD,
    ST_S_EVAL,
    ST_Q_WALK,
    ST_Q_EVAL,
    ST_FIN
  } state_t;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    cnt_t ok;
    cnt_t cau;
    cnt_t crit;
  } tally_t;

  typedef struct packed {
    logic             clr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    cls_t             wr_cls;
    logic [IDX_W-1:0] rd_addr;
  } ring_req_t;

  typedef struct packed {
    logic clr;
    logic inc;
    cls_t cls;
  } tally_ctl_t;

  // critical beats the rest combined, else any trouble beats ok
  function automatic cls_t majority(input tally_t t);
    logic [CNT_W:0] ok_cau;
    logic [CNT_W:0] bad;
    ok_cau = {1'b0, t.ok} + {1'b0, t.cau};
    bad    = {1'b0, t.cau} + {1'b0, t.crit};
    if ({1'b0, t.crit} > ok_cau) return CLS_CRITICAL;
    if (bad > {1'b0, t.ok}) return CLS_CAUTION;
    return CLS_OK;
  endfunction

endpackage

@@ rtl/awmm_ring.sv @@
// ----------------------------------------------------------------------------
// awmm_ring: window class store
// One write and one registered read per cycle; per-entry valid bits make
// unwritten entries read as empty after reset or a window length change.
// ----------------------------------------------------------------------------
module awmm_ring (
  input  logic                clk,
  input  logic                rst_n,
  input  awmm_pkg::ring_req_t req,
  output awmm_pkg::cls_t      rd_cls
);

  logic [1:0]                          mem [awmm_pkg::WINDOW_DEPTH];
  logic [awmm_pkg::WINDOW_DEPTH-1:0]   valid_r;
  logic [1:0]                          rd_data_r;
  logic                                rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_cls;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r <= valid_r[req.rd_addr];
  end

  assign rd_cls = rd_valid_r ? awmm_pkg::cls_t'(rd_data_r) : awmm_pkg::CLS_EMPTY;

endmodule

@@ rtl/awmm_tally.sv @@
// ----------------------------------------------------------------------------
// awmm_tally: per-class counter bank for the query walk
// Counts one class per cycle; empty entries are skipped.
// ----------------------------------------------------------------------------
module awmm_tally (
  input  logic                 clk,
  input  logic                 rst_n,
  input  awmm_pkg::tally_ctl_t ctl,
  output awmm_pkg::tally_t     cnt
);

  awmm_pkg::tally_t cnt_r;
  awmm_pkg::tally_t cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.clr) begin
      cnt_nxt = '0;
    end else if (ctl.inc) begin
      case (ctl.cls)
        awmm_pkg::CLS_OK:       cnt_nxt.ok   = cnt_r.ok   + awmm_pkg::cnt_t'(1);
        awmm_pkg::CLS_CAUTION:  cnt_nxt.cau  = cnt_r.cau  + awmm_pkg::cnt_t'(1);
        awmm_pkg::CLS_CRITICAL: cnt_nxt.crit = cnt_r.crit + awmm_pkg::cnt_t'(1);
        default:                cnt_nxt      = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt = cnt_r;

endmodule

@@ rtl/airflow_window_majority_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// airflow_window_majority_monitor_unit: airflow window majority monitor
// Classifies airflow samples, keeps a ring of classes with per-class counts,
// raises caution/critical reports and answers majority queries.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: operation; tdata: reading,
//          |     |                    |   printing, recent_count
//  out_    | out | out_tvalid/tready  | tdata: instant, window, report,
//          |     |                    |   error_active, query_status
//  cfg_    | in  | cfg_we             | cfg_addr register index, cfg_wdata
//
//  Steps per item: a sample is accepted, then reads and updates the ring, is
//  evaluated and output; clear, unused code, bypassed sample and short queries
//  go from acceptance straight to output; a walking query reads its examined
//  entries through the single ring read port, one entry a cycle.
//  Reset (rst_n, synchronous): ring valid bits clear together, no sweep.
//  One item in flight; the next is taken while a result waits in the output
//  register, and the result holds until out_tready.
//
module airflow_window_majority_monitor_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] reading, [8] printing, [16:9] recent_count, [23:17] zero
  input  logic [awmm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] operation
  input  logic [awmm_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] instant_status, [3:2] window_status, [5:4] report_code,
  // [6] error_active, [8:7] query_status, [15:9] zero
  output logic [awmm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [awmm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [awmm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // input fields
  awmm_pkg::op_t                   in_op;
  logic [awmm_pkg::READING_W-1:0]  in_reading;
  logic                            in_printing;
  logic [awmm_pkg::COUNT_W-1:0]    in_count;

  assign in_op       = awmm_pkg::op_t'(in_tuser[1:0]);
  assign in_reading  = in_tdata[7:0];
  assign in_printing = in_tdata[8];
  assign in_count    = in_tdata[16:9];

  // config
  logic [awmm_pkg::LIMIT_W-1:0] caut_lim_r, caut_lim_nxt;
  logic [awmm_pkg::LIMIT_W-1:0] crit_lim_r, crit_lim_nxt;
  logic [awmm_pkg::LIMIT_W-1:0] fault_lim_r, fault_lim_nxt;
  logic                         bypass_r, bypass_nxt;
  logic [awmm_pkg::LEN_W-1:0]   len_r, len_nxt;

  // sequencer and state
  awmm_pkg::state_t               state_r, state_nxt;
  logic [awmm_pkg::IDX_W-1:0]     head_r, head_nxt;
  awmm_pkg::tally_t               win_cnt_r, win_cnt_nxt;
  logic [awmm_pkg::READING_W-1:0] cur_rd_r, cur_rd_nxt;
  awmm_pkg::cls_t                 last_inst_r, last_inst_nxt;
  awmm_pkg::cls_t                 last_win_r, last_win_nxt;
  awmm_pkg::cls_t                 prev_win_r, prev_win_nxt;
  logic                           err_r, err_nxt;
  awmm_pkg::cls_t                 inst_r, inst_nxt;
  logic                           printing_r, printing_nxt;
  logic [1:0]                     report_r, report_nxt;
  logic [1:0]                     qstat_r, qstat_nxt;
  logic [awmm_pkg::LEN_W-1:0]     rem_r, rem_nxt;
  logic [awmm_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                           pend_r, pend_nxt;
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [awmm_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // shared units
  awmm_pkg::ring_req_t  ring_req;
  awmm_pkg::cls_t       ring_cls;
  awmm_pkg::tally_ctl_t tally_ctl;
  awmm_pkg::tally_t     q_cnt;

  awmm_ring u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ring_req),
    .rd_cls (ring_cls)
  );

  awmm_tally u_tally (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tally_ctl),
    .cnt   (q_cnt)
  );

  // head pointer folded into the current window
  logic [awmm_pkg::IDX_W-1:0] head_eff;
  logic [awmm_pkg::LEN_W-1:0] head_inc;
  logic [awmm_pkg::IDX_W-1:0] idx_step;
  logic [awmm_pkg::CMP_W-1:0] cnt_cmp;
  logic [awmm_pkg::CMP_W-1:0] len_cmp;
  logic [awmm_pkg::CMP_W-1:0] wlen_cmp;
  logic [awmm_pkg::LEN_W-1:0] wlen_eff;
  awmm_pkg::cls_t             win_eval;
  awmm_pkg::cls_t             sample_cls;

  assign head_eff = (awmm_pkg::LEN_W'(head_r) >= len_r) ? '0 : head_r;
  assign head_inc = awmm_pkg::LEN_W'(head_eff) + awmm_pkg::LEN_W'(1);
  assign idx_step = (idx_r == '0) ? awmm_pkg::IDX_W'(len_r - awmm_pkg::LEN_W'(1))
                                  : idx_r - awmm_pkg::IDX_W'(1);
  assign cnt_cmp  = awmm_pkg::CMP_W'(in_count);
  assign len_cmp  = awmm_pkg::CMP_W'(len_r);
  assign wlen_cmp = awmm_pkg::CMP_W'(cfg_wdata);
  assign win_eval = awmm_pkg::majority(win_cnt_r);

  // window length 0 acts as 1, above depth acts as depth
  always_comb begin
    if (cfg_wdata == '0) begin
      wlen_eff = awmm_pkg::LEN_W'(1);
    end else if (wlen_cmp > awmm_pkg::CMP_W'(awmm_pkg::WINDOW_DEPTH)) begin
      wlen_eff = awmm_pkg::DEPTH_LEN;
    end else begin
      wlen_eff = awmm_pkg::LEN_W'(cfg_wdata);
    end
  end

  always_comb begin
    if (in_reading < crit_lim_r) begin
      sample_cls = awmm_pkg::CLS_CRITICAL;
    end else if (in_reading < caut_lim_r) begin
      sample_cls = awmm_pkg::CLS_CAUTION;
    end else begin
      sample_cls = awmm_pkg::CLS_OK;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    caut_lim_nxt   = caut_lim_r;
    crit_lim_nxt   = crit_lim_r;
    fault_lim_nxt  = fault_lim_r;
    bypass_nxt     = bypass_r;
    len_nxt        = len_r;
    head_nxt       = head_r;
    win_cnt_nxt    = win_cnt_r;
    cur_rd_nxt     = cur_rd_r;
    last_inst_nxt  = last_inst_r;
    last_win_nxt   = last_win_r;
    prev_win_nxt   = prev_win_r;
    err_nxt        = err_r;
    inst_nxt       = inst_r;
    printing_nxt   = printing_r;
    report_nxt     = report_r;
    qstat_nxt      = qstat_r;
    rem_nxt        = rem_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    out_data_nxt   = out_data_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    in_tready      = 1'b0;

    ring_req.clr     = 1'b0;
    ring_req.wr_en   = 1'b0;
    ring_req.wr_addr = head_eff;
    ring_req.wr_cls  = inst_r;
    ring_req.rd_addr = head_eff;

    tally_ctl.clr = 1'b0;
    tally_ctl.inc = pend_r;
    tally_ctl.cls = ring_cls;

    case (state_r)
      awmm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          report_nxt = 2'd0;
          qstat_nxt  = 2'd0;
          state_nxt  = awmm_pkg::ST_FIN;
          case (in_op)
            awmm_pkg::OP_SAMPLE: begin
              cur_rd_nxt = in_reading;
              if (bypass_r) begin
                last_inst_nxt = awmm_pkg::CLS_OK;
                last_win_nxt  = awmm_pkg::CLS_OK;
                prev_win_nxt  = awmm_pkg::CLS_OK;
                err_nxt       = 1'b0;
              end else begin
                // ring read of the entry about to be overwritten
                inst_nxt     = sample_cls;
                printing_nxt = in_printing;
                state_nxt    = awmm_pkg::ST_S_UPD;
              end
            end
            awmm_pkg::OP_QUERY: begin
              if (in_count == awmm_pkg::COUNT_W'(1) &&
                  cur_rd_r <= fault_lim_r) begin
                qstat_nxt = awmm_pkg::Q_DISCONNECTED;
              end else if (in_count == '0) begin
                qstat_nxt = win_eval;
              end else begin
                rem_nxt       = (cnt_cmp > len_cmp) ? len_r
                                                    : awmm_pkg::LEN_W'(cnt_cmp);
                idx_nxt       = head_eff;
                tally_ctl.clr = 1'b1;
                state_nxt     = awmm_pkg::ST_Q_WALK;
              end
            end
            awmm_pkg::OP_CLEAR: begin
              prev_win_nxt = awmm_pkg::CLS_OK;
            end
            default: begin
              state_nxt = awmm_pkg::ST_FIN;
            end
          endcase
        end
      end

      awmm_pkg::ST_S_UPD: begin
        ring_req.wr_en = 1'b1;
        head_nxt = (head_inc >= len_r) ? '0 : awmm_pkg::IDX_W'(head_inc);
        if (ring_cls != inst_r) begin
          case (ring_cls)
            awmm_pkg::CLS_OK:
              win_cnt_nxt.ok = win_cnt_r.ok - awmm_pkg::cnt_t'(1);
            awmm_pkg::CLS_CAUTION:
              win_cnt_nxt.cau = win_cnt_r.cau - awmm_pkg::cnt_t'(1);
            awmm_pkg::CLS_CRITICAL:
              win_cnt_nxt.crit = win_cnt_r.crit - awmm_pkg::cnt_t'(1);
            default: ;
          endcase
          case (inst_r)
            awmm_pkg::CLS_OK:
              win_cnt_nxt.ok = win_cnt_r.ok + awmm_pkg::cnt_t'(1);
            awmm_pkg::CLS_CAUTION:
              win_cnt_nxt.cau = win_cnt_r.cau + awmm_pkg::cnt_t'(1);
            awmm_pkg::CLS_CRITICAL:
              win_cnt_nxt.crit = win_cnt_r.crit + awmm_pkg::cnt_t'(1);
            default: ;
          endcase
        end
        state_nxt = awmm_pkg::ST_S_EVAL;
      end

      awmm_pkg::ST_S_EVAL: begin
        // report, while printing, on first appearance or worsening of the window status
        if (printing_r) begin
          if (win_eval == awmm_pkg::CLS_CRITICAL) begin
            if (!err_r || prev_win_r != awmm_pkg::CLS_CRITICAL) begin
              err_nxt    = 1'b1;
              report_nxt = awmm_pkg::CLS_CRITICAL;
            end
          end else if (win_eval == awmm_pkg::CLS_CAUTION) begin
            if (!err_r || prev_win_r == awmm_pkg::CLS_OK) begin
              err_nxt    = 1'b1;
              report_nxt = awmm_pkg::CLS_CAUTION;
            end
          end
        end
        if (win_eval == awmm_pkg::CLS_OK) begin
          err_nxt = 1'b0;
        end
        prev_win_nxt  = win_eval;
        last_win_nxt  = win_eval;
        last_inst_nxt = inst_r;
        state_nxt     = awmm_pkg::ST_FIN;
      end

      awmm_pkg::ST_Q_WALK: begin
        // newest first; tally takes each class in the cycle after its read
        if (rem_r != '0) begin
          ring_req.rd_addr = idx_step;
          idx_nxt          = idx_step;
          rem_nxt          = rem_r - awmm_pkg::LEN_W'(1);
          pend_nxt         = 1'b1;
        end else begin
          state_nxt = awmm_pkg::ST_Q_EVAL;
        end
      end

      awmm_pkg::ST_Q_EVAL: begin
        qstat_nxt = awmm_pkg::majority(q_cnt);
        state_nxt = awmm_pkg::ST_FIN;
      end

      awmm_pkg::ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = {7'd0, qstat_r, err_r, report_r, last_win_r, last_inst_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = awmm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = awmm_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (awmm_pkg::cfg_idx_t'(cfg_addr))
        awmm_pkg::CFG_CAUTION:  caut_lim_nxt  = cfg_wdata;
        awmm_pkg::CFG_CRITICAL: crit_lim_nxt  = cfg_wdata;
        awmm_pkg::CFG_FAULT:    fault_lim_nxt = cfg_wdata;
        awmm_pkg::CFG_BYPASS:   bypass_nxt    = cfg_wdata[0];
        awmm_pkg::CFG_WINLEN: begin
          len_nxt      = wlen_eff;
          head_nxt     = '0;
          win_cnt_nxt  = '0;
          ring_req.clr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= awmm_pkg::ST_IDLE;
      caut_lim_r   <= '0;
      crit_lim_r   <= '0;
      fault_lim_r  <= '0;
      bypass_r     <= 1'b0;
      len_r        <= awmm_pkg::RESET_LEN;
      head_r       <= '0;
      win_cnt_r    <= '0;
      cur_rd_r     <= awmm_pkg::RESET_READING;
      last_inst_r  <= awmm_pkg::CLS_OK;
      last_win_r   <= awmm_pkg::CLS_OK;
      prev_win_r   <= awmm_pkg::CLS_OK;
      err_r        <= 1'b0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      caut_lim_r   <= caut_lim_nxt;
      crit_lim_r   <= crit_lim_nxt;
      fault_lim_r  <= fault_lim_nxt;
      bypass_r     <= bypass_nxt;
      len_r        <= len_nxt;
      head_r       <= head_nxt;
      win_cnt_r    <= win_cnt_nxt;
      cur_rd_r     <= cur_rd_nxt;
      last_inst_r  <= last_inst_nxt;
      last_win_r   <= last_win_nxt;
      prev_win_r   <= prev_win_nxt;
      err_r        <= err_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    inst_r     <= inst_nxt;
    printing_r <= printing_nxt;
    report_r   <= report_nxt;
    qstat_r    <= qstat_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/awmm_checker.sv @@
// ----------------------------------------------------------------------------
// awmm_checker: port-level checks of the airflow window majority monitor
// Watches the result channel for reset behavior and field consistency.
// ----------------------------------------------------------------------------
module awmm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [awmm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // report and query answer never come from the same item
  a_report_or_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:4] == 2'd0 || out_tdata[8:7] == 2'd0))
    else $error("report and query status both set");

  // a report names the window status and latches the error flag
  a_report_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:4] != 2'd0 |->
      out_tdata[5:4] == out_tdata[3:2] && out_tdata[6])
    else $error("report disagrees with window status or error flag");

  // the error flag only stands while the window is not ok
  a_error_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[3:2] != 2'd0)
    else $error("error flag set with ok window");

endmodule

bind airflow_window_majority_monitor_unit awmm_checker u_awmm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
